>>> hdl/mrf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
package mrf_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam logic [7:0] COUNT_MAX = 8'(MAX_FRAME_BYTES - 9);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int JOB_BYTES = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_SEQUENCE = 2'd2;
  localparam logic [1:0] ST_CRC_BAD = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic [7:0] data_byte_one;
    logic [7:0] data_byte_two;
    logic [7:0] data_byte_three;
    logic [7:0] data_byte_four;
    logic [7:0] byte_count;
    logic [7:0] stream_byte;
    logic       check_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic                     msg;
    logic                     msg_end;
    logic [1:0]               msg_status;
    logic                     crc_init;
    logic                     crc_tail;
    logic [2:0]               nbytes;
    logic [JOB_BYTES*8-1:0]   data;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/mrf_front.sv
// Front end: classifies input transactions, tracks frame and check state, builds jobs.
module mrf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  mrf_pkg::in_t  in_item,
  output mrf_pkg::job_t job
);
  import mrf_pkg::*;

  logic        frame_open_r, frame_open_nxt;
  logic [7:0]  payload_left_r, payload_left_nxt;
  logic [15:0] check_crc_r, check_crc_nxt;
  logic [15:0] check_hold_r, check_hold_nxt;
  logic [1:0]  check_fill_r, check_fill_nxt;

  logic        is_fixed, is_multi;
  logic [7:0]  cnt;
  logic [15:0] crc_fed;
  logic [15:0] hold_new;
  logic [1:0]  fill_new;

  always_comb begin
    is_fixed = (in_item.function_code >= 8'd1) && (in_item.function_code <= 8'd6);
    is_multi = (in_item.function_code == 8'd15) || (in_item.function_code == 8'd16);
    cnt = (in_item.byte_count > COUNT_MAX) ? COUNT_MAX : in_item.byte_count;
    crc_fed = (check_fill_r == 2'd2) ? crc_feed(check_crc_r, check_hold_r[7:0]) : check_crc_r;
    hold_new = {in_item.stream_byte, check_hold_r[15:8]};
    fill_new = (check_fill_r == 2'd2) ? 2'd2 : check_fill_r + 2'd1;

    frame_open_nxt = frame_open_r;
    payload_left_nxt = payload_left_r;
    check_crc_nxt = check_crc_r;
    check_hold_nxt = check_hold_r;
    check_fill_nxt = check_fill_r;

    job = '0;
    job.msg = 1'b1;
    job.msg_end = 1'b1;
    job.msg_status = ST_SEQUENCE;

    case (in_item.opcode)
      OP_START: begin
        if (frame_open_r) begin
          job.msg_status = ST_SEQUENCE;
        end else if (!is_fixed && !is_multi) begin
          job.msg_status = ST_UNSUPPORTED;
        end else begin
          job.msg = 1'b0;
          job.crc_init = 1'b1;
          job.data = {cnt, in_item.data_byte_four, in_item.data_byte_three,
                      in_item.data_byte_two, in_item.data_byte_one,
                      in_item.function_code, in_item.slave_address};
          if (is_fixed) begin
            job.nbytes = 3'd6;
            job.crc_tail = 1'b1;
          end else begin
            job.nbytes = 3'd7;
            job.crc_tail = (cnt == 8'd0);
            payload_left_nxt = cnt;
            frame_open_nxt = (cnt != 8'd0);
          end
        end
      end
      OP_PAYLOAD: begin
        if (!frame_open_r || payload_left_r == 8'd0) begin
          frame_open_nxt = 1'b0;
          job.msg_status = ST_SEQUENCE;
        end else begin
          job.msg = 1'b0;
          job.nbytes = 3'd1;
          job.data = {{(JOB_BYTES-1)*8{1'b0}}, in_item.stream_byte};
          job.crc_tail = (payload_left_r == 8'd1);
          payload_left_nxt = payload_left_r - 8'd1;
          frame_open_nxt = (payload_left_r != 8'd1);
        end
      end
      OP_CHECK: begin
        job.msg_end = in_item.check_last;
        job.msg_status = ST_OK;
        if (in_item.check_last) begin
          if (fill_new != 2'd2 || crc_fed != hold_new) begin
            job.msg_status = ST_CRC_BAD;
          end
          check_crc_nxt = CRC_INIT;
          check_hold_nxt = '0;
          check_fill_nxt = '0;
        end else begin
          check_crc_nxt = crc_fed;
          check_hold_nxt = hold_new;
          check_fill_nxt = fill_new;
        end
      end
      default: begin
        job.msg_status = ST_SEQUENCE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      payload_left_r <= '0;
      check_crc_r <= CRC_INIT;
      check_hold_r <= '0;
      check_fill_r <= '0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      payload_left_r <= payload_left_nxt;
      check_crc_r <= check_crc_nxt;
      check_hold_r <= check_hold_nxt;
      check_fill_r <= check_fill_nxt;
    end
  end

endmodule

>>> hdl/mrf_queue.sv
// Short job queue between the front end and the serializer.
module mrf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mrf_pkg::job_t q_job
);
  import mrf_pkg::*;

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hdl/mrf_back.sv
// Serializer: emits queued jobs as one result per unstalled cycle; CRC closes frames.
module mrf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mrf_pkg::job_t q_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output mrf_pkg::out_t out_data
);
  import mrf_pkg::*;

  job_t        cur_r;
  logic        cur_valid_r;
  logic [3:0]  pos_r;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  out_t        out_r, out_nxt;

  logic        adv;
  logic [3:0]  total;
  logic        last_res;
  logic        is_data;
  logic [15:0] crc_in;

  assign adv = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    total = cur_r.msg ? 4'd1 : ({1'b0, cur_r.nbytes} + (cur_r.crc_tail ? 4'd2 : 4'd0));
    last_res = (pos_r == total - 4'd1);
    is_data = !cur_r.msg && (pos_r < {1'b0, cur_r.nbytes});
    crc_in = (pos_r == 4'd0 && cur_r.crc_init) ? CRC_INIT : crc_r;
    pop = q_valid && (!cur_valid_r || (adv && last_res));

    out_nxt = '0;
    crc_nxt = crc_r;
    if (cur_r.msg) begin
      out_nxt.frame_end = cur_r.msg_end;
      out_nxt.status = cur_r.msg_status;
    end else begin
      out_nxt.byte_valid = 1'b1;
      out_nxt.frame_end = last_res;
      out_nxt.status = ST_OK;
      if (is_data) begin
        out_nxt.out_byte = cur_r.data[7:0];
        crc_nxt = crc_feed(crc_in, cur_r.data[7:0]);
      end else if (pos_r == {1'b0, cur_r.nbytes}) begin
        out_nxt.out_byte = crc_r[7:0];
      end else begin
        out_nxt.out_byte = crc_r[15:8];
        crc_nxt = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r <= '0;
      crc_r <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= cur_valid_r;
      end
      if (adv && cur_valid_r) begin
        crc_r <= crc_nxt;
      end
      if (pop) begin
        cur_valid_r <= 1'b1;
        cur_r <= q_job;
        pos_r <= '0;
      end else if (adv && cur_valid_r) begin
        pos_r <= pos_r + 4'd1;
        if (is_data) begin
          cur_r.data <= cur_r.data >> 8;
        end
        if (last_res) begin
          cur_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cur_valid_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> hdl/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer and frame checker.
// Input channel in_valid/in_stall/in_data carries one transaction per item: a start
// (slave address, function code, four header bytes, byte count), a payload byte, or
// a received byte to check. Output channel out_valid/out_stall/out_data carries the
// results of each transaction: frame bytes, CRC low then high, with frame_end on the
// last result of each item (of checked bytes, only the last) and a status code.
// Throughput: one input item per cycle while the four-entry job queue has room, and
// one result per cycle on the output while out_stall is low; a start item yields up
// to nine results, so a burst of starts is paced by the serializer.
// The first result of an item passes through the job queue, serializer load and
// output register before it is presented, and is taken while out_stall is low.
// Reset clears the frame, payload and check state, the queue and the output valid flag.
// When the receiver stalls, the output register holds its result, the serializer
// stops, the queue fills and in_stall rises once it is full.
module modbus_rtu_request_framer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mrf_pkg::out_t out_data
);
  import mrf_pkg::*;

  logic accept;
  logic full;
  logic pop;
  logic q_valid;
  job_t front_job;
  job_t q_job;

  assign in_stall = full;
  assign accept = in_valid && !full;

  mrf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .job     (front_job)
  );

  mrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_job (front_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  mrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
